/* src/pic_pkg.sv */
// ----------------------------------------------------------------------------
// Interrupt controller package
// Shared constants, command codes, queue entry and state types.
// ----------------------------------------------------------------------------
`default_nettype none
package pic_pkg;
   localparam int unsigned SOURCES  = 31;
   localparam int unsigned CONTEXTS = 2;
   localparam int unsigned SRC_W    = 5;
   localparam int unsigned CTX_W    = 1;
   localparam int unsigned QDEPTH   = 2;

   localparam logic [21:0] PEND_BASE  = 22'h001000;
   localparam logic [21:0] ENAB_BASE  = 22'h002000;
   localparam logic [21:0] CTX_BASE   = 22'h200000;

   typedef enum logic [1:0] {
      CMD_READ  = 2'd0,
      CMD_WRITE = 2'd1,
      CMD_RAISE = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Decoded register target.
   typedef enum logic [2:0] {
      REG_NONE,
      REG_PRIO,
      REG_PEND,
      REG_ENAB,
      REG_THRESH,
      REG_CLAIM
   } reg_type;

   // One classified beat passed from front to back.
   typedef struct packed {
      cmd_type          cmd;
      reg_type          target;
      logic [SRC_W-1:0] index;
      logic [CTX_W-1:0] ctx;
      logic [31:0]      wdata;
      logic [31:0]      bmask;
      logic [SRC_W-1:0] source;
   } entry_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

/* src/pic_if.sv */
// ----------------------------------------------------------------------------
// Valid/ready channel
// Carries one payload beat with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none
interface pic_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  command;
   logic [21:0] address;
   logic [31:0] write_data;
   logic [3:0]  byte_enable;
   logic [4:0]  source;
   modport source_mp (output valid, command, address, write_data, byte_enable, source,
                      input ready);
   modport sink (input valid, command, address, write_data, byte_enable, source,
                 output ready);
endinterface

interface pic_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [1:0]  irq_lines;
   modport source_mp (output valid, read_data, irq_lines, input ready);
   modport sink (input valid, read_data, irq_lines, output ready);
endinterface
`default_nettype wire

/* src/pic_front.sv */
// ----------------------------------------------------------------------------
// Interrupt controller front end
// Accepts request beats, decodes the address and queues classified entries.
// ----------------------------------------------------------------------------
`default_nettype none
module pic_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   pic_req_if.sink                   req,
   output pic_pkg::entry_type        q_entry,
   output logic                      q_valid,
   input  wire logic                 q_pop
);
   pic_pkg::entry_type q_ff [pic_pkg::QDEPTH];
   logic [0:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   pic_pkg::entry_type dec;
   logic [21:0] a;
   logic [21:0] rel;
   logic push;

   // Decode the address into a register target.
   always_comb begin
      a   = {req.address[21:2], 2'b00};
      rel = '0;
      dec = '0;
      dec.cmd    = pic_pkg::cmd_type'(req.command);
      dec.wdata  = req.write_data;
      dec.source = req.source;
      dec.target = pic_pkg::REG_NONE;
      for (int b = 0; b < 4; b++) begin
         dec.bmask[8*b +: 8] = {8{req.byte_enable[b]}};
      end
      if (a >= 22'd4 && a < 22'(4 * (pic_pkg::SOURCES + 1))) begin
         dec.target = pic_pkg::REG_PRIO;
         dec.index  = a[2 +: pic_pkg::SRC_W];
      end else if (a == pic_pkg::PEND_BASE) begin
         dec.target = pic_pkg::REG_PEND;
      end else if (a >= pic_pkg::ENAB_BASE && a < pic_pkg::CTX_BASE) begin
         rel = a - pic_pkg::ENAB_BASE;
         if (rel[20:7] < 14'(pic_pkg::CONTEXTS) && rel[6:2] == 5'd0) begin
            dec.target = pic_pkg::REG_ENAB;
            dec.ctx    = rel[7 +: pic_pkg::CTX_W];
         end
      end else if (a >= pic_pkg::CTX_BASE) begin
         rel = a - pic_pkg::CTX_BASE;
         if (rel[20:12] < 9'(pic_pkg::CONTEXTS)) begin
            dec.ctx = rel[12 +: pic_pkg::CTX_W];
            if (rel[11:0] == 12'd0) begin
               dec.target = pic_pkg::REG_THRESH;
            end else if (rel[11:0] == 12'd4) begin
               dec.target = pic_pkg::REG_CLAIM;
            end
         end
      end
   end

   assign req.ready = (count_ff != 2'(pic_pkg::QDEPTH));
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign q_entry   = q_ff[rd_ptr_ff];

   // Queue pointers.
   always_comb begin
      wr_ptr_in = wr_ptr_ff + 1'(push);
      rd_ptr_in = rd_ptr_ff + 1'(q_pop);
      count_in  = count_ff + 2'(push) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= dec;
      end
   end
endmodule
`default_nettype wire

/* src/pic_back.sv */
// ----------------------------------------------------------------------------
// Interrupt controller back end
// Executes queued entries, rescans sources one per cycle, returns results.
// ----------------------------------------------------------------------------
`default_nettype none
module pic_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  pic_pkg::entry_type        q_entry,
   input  wire logic                 q_valid,
   output logic                      q_pop,
   pic_rsp_if.source_mp              rsp
);
   localparam int unsigned C = pic_pkg::CONTEXTS;

   logic [31:0] prio_ff [1:pic_pkg::SOURCES];
   logic [31:0] pend_ff;
   logic [31:0] enab_ff [C];
   logic [31:0] thr_ff  [C];
   logic [31:0] clmd_ff [C];
   logic [pic_pkg::SRC_W-1:0] claim_ff [C];

   pic_pkg::state_type state_ff, state_in;
   logic [pic_pkg::SRC_W-1:0] scan_ff, best_ff;
   logic [31:0] bprio_ff, rd_ff;
   logic        ovalid_ff;
   logic [31:0] odata_ff;
   logic [1:0]  olines_ff;

   pic_pkg::entry_type e;
   logic        start, rescan, scan_last, out_free;
   logic [31:0] rd;
   logic [pic_pkg::SRC_W-1:0] cs;
   logic [31:0] ws;

   assign e        = q_entry;
   assign out_free = !ovalid_ff || rsp.ready;
   assign start    = (state_ff == pic_pkg::ST_IDLE) && q_valid;
   assign q_pop    = start;
   assign scan_last = (scan_ff == pic_pkg::SRC_W'(pic_pkg::SOURCES));
   assign cs       = claim_ff[e.ctx];
   assign ws       = e.wdata & e.bmask;

   // Whether this entry triggers a rescan.
   always_comb begin
      rescan = 1'b0;
      unique case (e.cmd)
         pic_pkg::CMD_READ:  rescan = (e.target == pic_pkg::REG_CLAIM) && (e.bmask != '0);
         pic_pkg::CMD_WRITE: rescan = 1'b1;
         pic_pkg::CMD_RAISE: rescan = (e.source != '0);
         default:            rescan = 1'b0;
      endcase
   end

   // Register read mux.
   always_comb begin
      rd = '0;
      if (e.cmd == pic_pkg::CMD_READ) begin
         unique case (e.target)
            pic_pkg::REG_PRIO:   rd = prio_ff[e.index];
            pic_pkg::REG_PEND:   rd = pend_ff;
            pic_pkg::REG_ENAB:   rd = enab_ff[e.ctx];
            pic_pkg::REG_THRESH: rd = thr_ff[e.ctx];
            pic_pkg::REG_CLAIM:  rd = 32'(cs);
            default:             rd = '0;
         endcase
      end
      rd = rd & e.bmask;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pic_pkg::ST_IDLE: if (q_valid) state_in = rescan ? pic_pkg::ST_SCAN : pic_pkg::ST_DONE;
         pic_pkg::ST_SCAN: if (scan_last) state_in = pic_pkg::ST_DONE;
         pic_pkg::ST_DONE: if (out_free) state_in = pic_pkg::ST_IDLE;
         default:          state_in = pic_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pic_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Register file updates, scan and claim assignment.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
         for (int i = 1; i <= pic_pkg::SOURCES; i++) prio_ff[i] <= '0;
         for (int c = 0; c < C; c++) begin
            enab_ff[c]  <= '0;
            thr_ff[c]   <= '0;
            clmd_ff[c]  <= '0;
            claim_ff[c] <= '0;
         end
      end else if (start) begin
         rd_ff   <= rd;
         scan_ff <= pic_pkg::SRC_W'(1);
         best_ff <= '0;
         bprio_ff <= '0;
         if (e.cmd == pic_pkg::CMD_READ && e.target == pic_pkg::REG_CLAIM &&
             e.bmask != '0 && cs != '0) begin
            clmd_ff[e.ctx][cs] <= 1'b1;
            pend_ff[cs]        <= 1'b0;
         end
         if (e.cmd == pic_pkg::CMD_WRITE) begin
            unique case (e.target)
               pic_pkg::REG_PRIO:
                  prio_ff[e.index] <= (prio_ff[e.index] & ~e.bmask) | ws;
               pic_pkg::REG_ENAB:
                  enab_ff[e.ctx] <= (enab_ff[e.ctx] & ~e.bmask) | ws;
               pic_pkg::REG_THRESH:
                  thr_ff[e.ctx] <= (thr_ff[e.ctx] & ~e.bmask) | ws;
               pic_pkg::REG_CLAIM:
                  if (e.bmask != '0 && ws <= 32'(pic_pkg::SOURCES) &&
                      enab_ff[e.ctx][ws[4:0]]) begin
                     clmd_ff[e.ctx][ws[4:0]] <= 1'b0;
                  end
               default: ;
            endcase
         end
         if (e.cmd == pic_pkg::CMD_RAISE && e.source != '0) begin
            pend_ff[e.source] <= 1'b1;
         end
      end else if (state_ff == pic_pkg::ST_SCAN) begin
         // One source per cycle; strict compare keeps the lowest number on ties.
         if (pend_ff[scan_ff] && prio_ff[scan_ff] > bprio_ff) begin
            best_ff  <= scan_ff;
            bprio_ff <= prio_ff[scan_ff];
         end
         scan_ff <= scan_ff + 1'b1;
         if (scan_last) begin
            for (int c = 0; c < C; c++) begin
               if (pend_ff[scan_ff] && prio_ff[scan_ff] > bprio_ff) begin
                  claim_ff[c] <= (prio_ff[scan_ff] > thr_ff[c] && !clmd_ff[c][scan_ff] &&
                                  enab_ff[c][scan_ff]) ? scan_ff : '0;
               end else begin
                  claim_ff[c] <= (bprio_ff > thr_ff[c] && !clmd_ff[c][best_ff] &&
                                  enab_ff[c][best_ff]) ? best_ff : '0;
               end
            end
         end
      end
   end

   // Output register: a new beat loads when done, a taken beat clears.
   always_ff @(posedge clock) begin
      if (reset) begin
         ovalid_ff <= 1'b0;
      end else if (state_ff == pic_pkg::ST_DONE && out_free) begin
         ovalid_ff <= 1'b1;
      end else if (rsp.ready) begin
         ovalid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == pic_pkg::ST_DONE && out_free) begin
         odata_ff <= rd_ff;
         for (int c = 0; c < C; c++) olines_ff[c] <= (claim_ff[c] != '0);
      end
   end

   assign rsp.valid     = ovalid_ff;
   assign rsp.read_data = odata_ff;
   assign rsp.irq_lines = olines_ff;
endmodule
`default_nettype wire

/* src/platform_interrupt_controller.sv */
// ----------------------------------------------------------------------------
// Platform interrupt controller
// Priority-based interrupt controller with two contexts and 31 sources.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload
//  req     | in        | command, address, write_data, byte_enable, source
//  rsp     | out       | read_data, irq_lines
//
// An event that changes state is executed first, then the one-source-per-cycle
// priority scan runs over every source, then result. Other beats skip the scan.
// Reset is synchronous and clears the pointers, FSM, register file and valid.
// A two-entry queue lets requests be taken while the back end is busy;
// the result register holds a beat until rsp.ready.
`default_nettype none
module platform_interrupt_controller (
   input  wire logic    clock,
   input  wire logic    reset,
   pic_req_if.sink      req,
   pic_rsp_if.source_mp rsp
);
   pic_pkg::entry_type q_entry;
   logic q_valid, q_pop;

   pic_front u_front (
      .clock, .reset, .req, .q_entry, .q_valid, .q_pop
   );

   pic_back u_back (
      .clock, .reset, .q_entry, .q_valid, .q_pop, .rsp
   );
endmodule
`default_nettype wire

/* tb/pic_tb_if.sv */
// ----------------------------------------------------------------------------
// Interrupt controller testbench package
// The block's channels are declared with the RTL; this file holds the type of
// one expected response beat for the testbench.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
package pic_tb_pkg;
   // One expected result beat.
   typedef struct {
      logic [31:0] read_data;
      logic [1:0]  irq_lines;
   } irq_result_type;
endpackage

/* tb/platform_interrupt_controller_tb.sv */
// ----------------------------------------------------------------------------
// Platform interrupt controller testbench
// Drives register reads, writes and source raises through the request channel
// and checks every response beat against a cycle-free model of the priority
// scan, the claim and completion registers and the interrupt lines.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
module platform_interrupt_controller_tb;
   localparam int unsigned SOURCES  = pic_pkg::SOURCES;
   localparam int unsigned CONTEXTS = pic_pkg::CONTEXTS;
   localparam logic [21:0] PEND_BASE = pic_pkg::PEND_BASE;
   localparam logic [21:0] ENAB_BASE = pic_pkg::ENAB_BASE;
   localparam logic [21:0] CTX_BASE  = pic_pkg::CTX_BASE;
   localparam logic [21:0] CLAIM_OFS = 22'h4;
   localparam logic [21:0] CTX_STEP  = 22'h1000;
   localparam logic [21:0] ENAB_STEP = 22'h80;

   logic clock;
   logic reset;

   pic_req_if req ();
   pic_rsp_if rsp ();

   platform_interrupt_controller DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source_mp)
   );

   // Model state.
   logic [31:0] prio_mdl [1:SOURCES];
   logic [31:0] pend_mdl;
   logic [31:0] enab_mdl [CONTEXTS];
   logic [31:0] thresh_mdl [CONTEXTS];
   logic [31:0] claimed_mdl [CONTEXTS];
   logic [4:0]  claim_mdl [CONTEXTS];

   pic_tb_pkg::irq_result_type expected_q [$];
   int          send_idle_pct;
   int          recv_stall_pct;
   bit          hold_off;
   int          mismatches;
   int          beats_checked;
   int          claims_taken;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Rescan for the best pending source and hand it to each context.
   function automatic void rescan();
      logic [4:0]  best;
      logic [31:0] best_prio;
      best = '0;
      best_prio = '0;
      for (int s = 1; s <= SOURCES; s++) begin
         if (pend_mdl[s] && prio_mdl[s] > best_prio) begin
            best = s[4:0];
            best_prio = prio_mdl[s];
         end
      end
      for (int c = 0; c < CONTEXTS; c++) begin
         if (best_prio > thresh_mdl[c] && !claimed_mdl[c][best] && enab_mdl[c][best])
            claim_mdl[c] = best;
         else
            claim_mdl[c] = '0;
      end
   endfunction

   // Apply one request to the model and return its response.
   function automatic pic_tb_pkg::irq_result_type apply_event(pic_pkg::cmd_type cmd,
                                                              logic [21:0] addr_in,
                                                              logic [31:0] wd,
                                                              logic [3:0] be,
                                                              logic [4:0] src);
      pic_tb_pkg::irq_result_type r;
      logic [21:0] addr;
      logic [31:0] bm;
      logic [31:0] rd;
      logic [21:0] ofs;
      int          ctx;
      int          word;
      int          claim_ctx;
      logic [31:0] done_src;
      addr = {addr_in[21:2], 2'b00};
      rd = '0;
      claim_ctx = -1;
      for (int b = 0; b < 4; b++) bm[8*b +: 8] = {8{be[b]}};
      case (cmd)
         pic_pkg::CMD_READ: begin
            if (addr >= 4 && addr < 4 * (SOURCES + 1)) begin
               rd = prio_mdl[addr / 4];
            end else if (addr == PEND_BASE) begin
               rd = pend_mdl;
            end else if (addr >= ENAB_BASE && addr < CTX_BASE) begin
               ofs = addr - ENAB_BASE;
               ctx = ofs / ENAB_STEP;
               word = (ofs % ENAB_STEP) / 4;
               if (ctx < CONTEXTS && word == 0) rd = enab_mdl[ctx];
            end else if (addr >= CTX_BASE) begin
               ofs = addr - CTX_BASE;
               ctx = ofs / CTX_STEP;
               if (ctx < CONTEXTS) begin
                  if (ofs % CTX_STEP == 0) begin
                     rd = thresh_mdl[ctx];
                  end else if (ofs % CTX_STEP == CLAIM_OFS) begin
                     rd = claim_mdl[ctx];
                     if (bm != 0) claim_ctx = ctx;
                  end
               end
            end
            rd &= bm;
            if (claim_ctx >= 0) begin
               if (claim_mdl[claim_ctx] != 0) begin
                  claimed_mdl[claim_ctx][claim_mdl[claim_ctx]] = 1'b1;
                  pend_mdl[claim_mdl[claim_ctx]] = 1'b0;
                  claims_taken++;
               end
               rescan();
            end
         end
         pic_pkg::CMD_WRITE: begin
            if (addr >= 4 && addr < 4 * (SOURCES + 1)) begin
               prio_mdl[addr / 4] = (prio_mdl[addr / 4] & ~bm) | (wd & bm);
            end else if (addr >= ENAB_BASE && addr < CTX_BASE) begin
               ofs = addr - ENAB_BASE;
               ctx = ofs / ENAB_STEP;
               word = (ofs % ENAB_STEP) / 4;
               if (ctx < CONTEXTS && word == 0)
                  enab_mdl[ctx] = (enab_mdl[ctx] & ~bm) | (wd & bm);
            end else if (addr >= CTX_BASE) begin
               ofs = addr - CTX_BASE;
               ctx = ofs / CTX_STEP;
               if (ctx < CONTEXTS) begin
                  if (ofs % CTX_STEP == 0) begin
                     thresh_mdl[ctx] = (thresh_mdl[ctx] & ~bm) | (wd & bm);
                  end else if (ofs % CTX_STEP == CLAIM_OFS && bm != 0) begin
                     done_src = wd & bm;
                     if (done_src <= SOURCES && enab_mdl[ctx][done_src[4:0]])
                        claimed_mdl[ctx][done_src[4:0]] = 1'b0;
                  end
               end
            end
            rescan();
         end
         pic_pkg::CMD_RAISE: begin
            if (src != 0) begin
               pend_mdl[src] = 1'b1;
               rescan();
            end
         end
         default: ;
      endcase
      r.read_data = rd;
      for (int c = 0; c < 2; c++) r.irq_lines[c] = (claim_mdl[c] != 0);
      return r;
   endfunction

   // Offer one beat, wait for acceptance, then record the expected response.
   // Valid drops only while the sender idles, so back-to-back beats keep it high.
   task automatic send_beat(pic_pkg::cmd_type cmd, logic [21:0] addr, logic [31:0] wd,
                            logic [3:0] be, logic [4:0] src);
      if ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req.valid       <= 1'b1;
      req.command     <= cmd;
      req.address     <= addr;
      req.write_data  <= wd;
      req.byte_enable <= be;
      req.source      <= src;
      do @(posedge clock); while (!req.ready);
      expected_q.push_back(apply_event(cmd, addr, wd, be, src));
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   // Receiver: random stalls, plus a long hold-off on request.
   initial begin
      int held;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off) begin
            held = 0;
            rsp.ready <= 1'b0;
            while (held < 400) begin
               @(posedge clock);
               held++;
            end
            hold_off = 1'b0;
         end
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compare each response beat with the oldest expectation.
   always @(posedge clock) begin
      pic_tb_pkg::irq_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected response beat: read_data=%h irq_lines=%b",
                        rsp.read_data, rsp.irq_lines);
         end else begin
            exp_r = expected_q.pop_front();
            beats_checked++;
            if (rsp.read_data !== exp_r.read_data || rsp.irq_lines !== exp_r.irq_lines) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: read_data exp %h got %h, irq_lines exp %b got %b",
                           exp_r.read_data, rsp.read_data, exp_r.irq_lines, rsp.irq_lines);
            end
         end
      end
   end

   function automatic logic [21:0] prio_addr(int s);
      return 22'(4 * s);
   endfunction

   function automatic logic [21:0] ctx_addr(int c, logic [21:0] ofs);
      return CTX_BASE + 22'(c) * CTX_STEP + ofs;
   endfunction

   // A random address, mostly on mapped registers.
   function automatic logic [21:0] pick_addr();
      case ($urandom_range(9))
         0, 1:    return prio_addr($urandom_range(SOURCES, 1));
         2:       return PEND_BASE + 22'($urandom_range(1) * 4);
         3:       return ENAB_BASE + 22'($urandom_range(2)) * ENAB_STEP
                         + 22'($urandom_range(1) * 4);
         4:       return ctx_addr($urandom_range(2), 22'h0);
         5, 6, 7: return ctx_addr($urandom_range(1), CLAIM_OFS);
         8:       return 22'($urandom_range(3) << 2) | 22'($urandom_range(3));
         default: return 22'($urandom);
      endcase
   endfunction

   function automatic logic [3:0] pick_be();
      return ($urandom_range(4) == 0) ? 4'($urandom) : 4'hF;
   endfunction

   // Extremes of every field and each corner of the register map.
   task automatic test_directed();
      send_beat(pic_pkg::CMD_READ, 22'h0, '1, 4'hF, '0);
      send_beat(pic_pkg::CMD_WRITE, prio_addr(SOURCES), 32'hFFFF_FFFF, 4'hF, 5'd31);
      send_beat(pic_pkg::CMD_READ, prio_addr(SOURCES), '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_WRITE, prio_addr(1), 32'h0000_0007, 4'b0101, '0);
      send_beat(pic_pkg::CMD_WRITE, prio_addr(2), 32'h0000_0007, 4'h0, '0);
      send_beat(pic_pkg::CMD_WRITE, ENAB_BASE, 32'hFFFF_FFFF, 4'hF, '0);
      send_beat(pic_pkg::CMD_WRITE, ENAB_BASE + ENAB_STEP, 32'h0000_0006, 4'hF, '0);
      send_beat(pic_pkg::CMD_RAISE, '0, '0, '0, 5'd0);
      send_beat(pic_pkg::CMD_RAISE, '0, '0, '0, 5'd1);
      send_beat(pic_pkg::CMD_RAISE, '0, '0, '0, 5'd31);
      send_beat(pic_pkg::CMD_WRITE, PEND_BASE, '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_READ, PEND_BASE, '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_READ, ctx_addr(0, CLAIM_OFS), '0, 4'h0, '0);
      send_beat(pic_pkg::CMD_READ, ctx_addr(0, CLAIM_OFS) | 22'h3, '0, 4'b1000, '0);
      send_beat(pic_pkg::CMD_READ, ctx_addr(0, CLAIM_OFS), '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_READ, ctx_addr(1, CLAIM_OFS), '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_WRITE, ctx_addr(0, CLAIM_OFS), 32'hFFFF_FF1F, 4'b0001, '0);
      send_beat(pic_pkg::CMD_WRITE, ctx_addr(0, CLAIM_OFS), 32'd40, 4'hF, '0);
      send_beat(pic_pkg::CMD_WRITE, ctx_addr(1, 22'h0), 32'hFFFF_FFFF, 4'hF, '0);
      send_beat(pic_pkg::CMD_READ, ctx_addr(1, 22'h0), '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_READ, ctx_addr(2, 22'h0), '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_READ, 22'h3F_FFFF, '0, 4'hF, '0);
      send_beat(pic_pkg::CMD_WRITE, 22'h3F_FFFC, '1, 4'hF, '0);
      send_beat(pic_pkg::CMD_NOP, 22'h3F_FFFF, '1, 4'hF, 5'd31);
      send_beat(pic_pkg::CMD_WRITE, ctx_addr(1, 22'h0), '0, 4'hF, '0);
   endtask

   // Random traffic: mostly raise, claim, complete flows, with noise.
   task automatic test_random(int count);
      int s;
      int c;
      for (int i = 0; i < count; i++) begin
         s = $urandom_range(SOURCES, 1);
         c = $urandom_range(1);
         case ($urandom_range(9))
            0: send_beat(pic_pkg::CMD_WRITE, prio_addr(s), 32'($urandom_range(7)),
                         pick_be(), '0);
            1: send_beat(pic_pkg::CMD_RAISE, 22'($urandom), $urandom, 4'($urandom),
                         5'($urandom));
            2: send_beat(pic_pkg::CMD_READ, ctx_addr(c, CLAIM_OFS), $urandom, pick_be(), '0);
            3: send_beat(pic_pkg::CMD_WRITE, ctx_addr(c, CLAIM_OFS),
                         32'(claim_mdl[c] != 0 ? claim_mdl[c] : s), pick_be(), '0);
            4: send_beat(pic_pkg::CMD_WRITE, ENAB_BASE + 22'(c) * ENAB_STEP, $urandom,
                         pick_be(), '0);
            5: send_beat(pic_pkg::CMD_WRITE, ctx_addr(c, 22'h0), 32'($urandom_range(7)),
                         pick_be(), '0);
            6: send_beat(pic_pkg::CMD_READ, pick_addr(), $urandom, pick_be(), 5'($urandom));
            7: send_beat(pic_pkg::CMD_WRITE, pick_addr(), $urandom, 4'($urandom),
                         5'($urandom));
            8: send_beat(pic_pkg::cmd_type'($urandom_range(3)), 22'($urandom), $urandom,
                         4'($urandom), 5'($urandom));
            default: send_beat(pic_pkg::CMD_RAISE, '0, '0, '0, 5'(s));
         endcase
      end
   endtask

   // Stall the receiver long enough that the queue fills and req.ready drops.
   task automatic test_backpressure();
      hold_off = 1'b1;
      for (int i = 0; i < 8; i++)
         send_beat(pic_pkg::CMD_RAISE, '0, '0, '0, 5'($urandom_range(31, 1)));
      wait_drained();
   endtask

   initial begin
      mismatches = 0;
      beats_checked = 0;
      claims_taken = 0;
      hold_off = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      req.valid <= 1'b0;
      req.command <= pic_pkg::CMD_NOP;
      req.address <= '0;
      req.write_data <= '0;
      req.byte_enable <= '0;
      req.source <= '0;
      for (int s = 1; s <= SOURCES; s++) prio_mdl[s] = '0;
      pend_mdl = '0;
      for (int c = 0; c < CONTEXTS; c++) begin
         enab_mdl[c] = '0;
         thresh_mdl[c] = '0;
         claimed_mdl[c] = '0;
         claim_mdl[c] = '0;
      end
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_backpressure();
      test_random(250);
      send_idle_pct = 81;
      test_random(250);
      wait_drained();
      send_idle_pct = 0;
      recv_stall_pct = 81;
      test_random(250);
      send_idle_pct = 30;
      recv_stall_pct = 30;
      test_random(250);
      wait_drained();

      $display("Checked %0d response beats, %0d claims taken, %0d mismatches.",
               beats_checked, claims_taken, mismatches);
      if (mismatches == 0 && expected_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #20_000_000;
      $display("Timeout with %0d responses outstanding.", expected_q.size());
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

/* sim.f */
src/pic_pkg.sv
src/pic_if.sv
src/pic_front.sv
src/pic_back.sv
src/platform_interrupt_controller.sv
tb/pic_tb_if.sv
tb/platform_interrupt_controller_tb.sv
